// ===== rtl/stereo_brickwall_peak_limiter_macros.svh =====
// Assertion macros shared by the limiter checker.
`ifndef STEREO_BRICKWALL_PEAK_LIMITER_MACROS_SVH
`define STEREO_BRICKWALL_PEAK_LIMITER_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define SBPL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("limiter check failed in the same cycle");

// Check that a condition implies another in the next cycle.
`define SBPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("limiter check failed one cycle later");

`endif

// ===== rtl/sbpl_pkg.sv =====
// Package of types and constants for the stereo peak limiter.
`default_nettype none

package sbpl_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS = 32;

	// Unity gain in Q1.31
	localparam logic [31:0] GAIN_ONE = 32'h8000_0000;

	// Register reset values
	localparam logic [63:0] CEILING_RESET = 64'd8103210;
	localparam logic [31:0] ATTACK_RESET = 32'd4116397000;
	localparam logic [31:0] RELEASE_RESET = 32'd4294520000;
	localparam logic STEREO_RESET = 1'b1;

	// Register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CEILING = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ATTACK = 8'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_RELEASE = 8'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_STEREO = 8'd3;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PREP,
		ST_MUL_ENV,
		ST_ENV,
		ST_MUL_L,
		ST_MUL_R,
		ST_OUT
	} sbpl_state_t;

endpackage

`default_nettype wire

// ===== rtl/stereo_brickwall_peak_limiter.sv =====
// Stereo brickwall peak limiter: top level with divider and shared multiplier.
// A limiting frame runs through the 31-step restoring divider, then PREP, MUL_ENV, ENV,
// MUL_L, MUL_R and OUT; a frame under the ceiling skips the divider. The input stalls until
// the frame is through, and one shared 33x33 multiplier serves three products.
// The next frame is taken while a finished result word still waits at the output.
// Reset (arst_n low, asynchronous): registers to their defaults, envelope to unity, idle.
`default_nettype none

module stereo_brickwall_peak_limiter #(
	parameter int SAMPLE_BITS = sbpl_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [sbpl_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [sbpl_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [SAMPLE_BITS-1:0]        left_sample,
	input  logic signed [SAMPLE_BITS-1:0]        right_sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [SAMPLE_BITS-1:0]        left_out,
	output logic signed [SAMPLE_BITS-1:0]        right_out,
	output logic [31:0]                          applied_gain
);
	import sbpl_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int MW = 33;
	localparam int PW = 2 * MW;
	localparam int ENW = PW + 1;
	localparam int HW = ENW - 33;
	localparam int YW = PW - 31;
	localparam int DIV_STEPS = 31;
	localparam int CNT_BITS = $clog2(DIV_STEPS);
	localparam logic [63:0] FULL = 64'd1 << (SB - 1);
	localparam logic [SB-1:0] PEAK_FLOOR = SB'((FULL + 64'd500000) / 64'd1000000);
	localparam logic [SB-1:0] CEIL_RST = SB'(CEILING_RESET);
	localparam logic signed [SB-1:0] SAT_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] SAT_MIN = {1'b1, {(SB-1){1'b0}}};

	// Round half up by 2^31 and saturate to the sample range
	function automatic logic signed [SB-1:0] sat_round(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] rnd;
		logic signed [YW-1:0] y;
		rnd = p + $signed(PW'(64'h4000_0000));
		y = rnd[PW-1:31];
		if (y > YW'(SAT_MAX))
			return SAT_MAX;
		else if (y < YW'(SAT_MIN))
			return SAT_MIN;
		else
			return y[SB-1:0];
	endfunction

	sbpl_state_t state_q, state_d;

	logic [SB-1:0]          ceil_q;
	logic [31:0]            att_q;
	logic [31:0]            rel_q;
	logic                   stereo_q;
	logic [31:0]            env_q;
	logic signed [SB-1:0]   l_q;
	logic signed [SB-1:0]   r_q;
	logic [SB-1:0]          peak_q;
	logic [SB-1:0]          rem_q;
	logic [31:0]            quo_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic signed [MW-1:0]   diff_q;
	logic [31:0]            coef_q;
	logic signed [PW-1:0]   prod_q;
	logic signed [SB-1:0]   res_l_q;

	logic                   accept;
	logic                   load_out;
	logic                   div_last;
	logic signed [SB-1:0]   r_in;
	logic [SB-1:0]          mag_l;
	logic [SB-1:0]          mag_r;
	logic [SB-1:0]          peak_in;
	logic                   lim_in;
	logic [SB:0]            rem_sh;
	logic [SB:0]            rem_sub;
	logic signed [MW-1:0]   mul_a;
	logic signed [MW-1:0]   mul_b;
	logic signed [ENW-1:0]  env_sum;
	logic [31:0]            env_new;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign div_last  = (cnt_q == CNT_BITS'(DIV_STEPS - 1));

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceil_q   <= CEIL_RST;
			att_q    <= ATTACK_RESET;
			rel_q    <= RELEASE_RESET;
			stereo_q <= STEREO_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CEILING: ceil_q   <= cfg_data[SB-1:0];
				CFG_ATTACK:  att_q    <= cfg_data[31:0];
				CFG_RELEASE: rel_q    <= cfg_data[31:0];
				CFG_STEREO:  stereo_q <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	// Frame peak; mono forces the right sample to zero
	always_comb begin
		r_in    = stereo_q ? right_sample : '0;
		mag_l   = left_sample[SB-1] ? (~$unsigned(left_sample) + SB'(1)) : $unsigned(left_sample);
		mag_r   = r_in[SB-1] ? (~$unsigned(r_in) + SB'(1)) : $unsigned(r_in);
		peak_in = (mag_r > mag_l) ? mag_r : mag_l;
		lim_in  = (peak_in > ceil_q) && (peak_in > PEAK_FLOOR);
	end

	// One restoring divide step: shift in a zero, subtract when it fits
	assign rem_sh  = {rem_q, 1'b0};
	assign rem_sub = rem_sh - {1'b0, peak_q};

	// Operand selection for the shared multiplier
	always_comb begin
		unique case (state_q)
			ST_MUL_ENV: begin
				mul_a = diff_q;
				mul_b = $signed({1'b0, coef_q});
			end
			ST_MUL_L: begin
				mul_a = MW'(l_q);
				mul_b = $signed({1'b0, env_q});
			end
			ST_MUL_R: begin
				mul_a = MW'(r_q);
				mul_b = $signed({1'b0, env_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Envelope: target*2^32 + (env - target)*c + 2^31, top word, clamped to 0..1
	always_comb begin
		env_sum = ENW'(prod_q) + $signed({3'b000, quo_q, 32'd0})
			+ $signed({{(ENW-32){1'b0}}, GAIN_ONE});
		if (env_sum[ENW-1])
			env_new = '0;
		else if (env_sum[ENW-2:32] > HW'(GAIN_ONE))
			env_new = GAIN_ONE;
		else
			env_new = env_sum[63:32];
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and output load
	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = lim_in ? ST_DIV : ST_PREP;
			end
			ST_DIV: begin
				if (div_last)
					state_d = ST_PREP;
			end
			ST_PREP:    state_d = ST_MUL_ENV;
			ST_MUL_ENV: state_d = ST_ENV;
			ST_ENV:     state_d = ST_MUL_L;
			ST_MUL_L:   state_d = ST_MUL_R;
			ST_MUL_R:   state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// Envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			env_q <= GAIN_ONE;
		else if (state_q == ST_ENV)
			env_q <= env_new;
	end

	// Datapath: capture, divide, select the pole, multiply
	always_ff @(posedge clk) begin
		if (accept) begin
			l_q    <= left_sample;
			r_q    <= r_in;
			peak_q <= peak_in;
			rem_q  <= ceil_q;
			quo_q  <= lim_in ? 32'd0 : GAIN_ONE;
			cnt_q  <= '0;
		end
		if (state_q == ST_DIV) begin
			cnt_q <= cnt_q + CNT_BITS'(1);
			if (!rem_sub[SB]) begin
				rem_q <= rem_sub[SB-1:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh[SB-1:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (state_q == ST_PREP) begin
			coef_q <= (quo_q < env_q) ? att_q : rel_q;
			diff_q <= $signed({1'b0, env_q}) - $signed({1'b0, quo_q});
		end
		if (state_q == ST_MUL_ENV || state_q == ST_MUL_L || state_q == ST_MUL_R)
			prod_q <= mul_a * mul_b;
		if (state_q == ST_MUL_R)
			res_l_q <= sat_round(prod_q);
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (load_out)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			left_out     <= res_l_q;
			right_out    <= sat_round(prod_q);
			applied_gain <= env_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sbpl_checker.sv =====
// Port checker for the stereo peak limiter, bound to the top level.
`default_nettype none

`include "stereo_brickwall_peak_limiter_macros.svh"

module sbpl_checker #(
	parameter int SAMPLE_BITS = sbpl_pkg::SAMPLE_BITS_DEF
) (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 in_valid,
	input wire logic                                 in_stall,
	input wire logic                                 out_valid,
	input wire logic                                 out_stall,
	input wire logic signed [SAMPLE_BITS-1:0]        left_out,
	input wire logic signed [SAMPLE_BITS-1:0]        right_out,
	input wire logic [31:0]                          applied_gain
);
	import sbpl_pkg::*;

	// A stalled result word holds
	`SBPL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(left_out) && $stable(right_out) && $stable(applied_gain))

	// The gain never exceeds unity
	`SBPL_ASSERT_SAME(a_gain_range, clk, arst_n, out_valid, applied_gain <= GAIN_ONE)

	// A taken frame keeps the input busy for the next cycle
	`SBPL_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && !in_stall, in_stall)

	// No result appears straight after a frame is taken
	`SBPL_ASSERT_NEXT(a_no_early_result, clk, arst_n, in_valid && !in_stall, !$rose(out_valid))

endmodule

bind stereo_brickwall_peak_limiter sbpl_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sbpl_checker (.*);

`default_nettype wire
